// File: src/prd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants of the pinhole ray direction unit.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int unsigned PIX_W  = 12;
  localparam int unsigned SIDE_W = 13;
  localparam int unsigned TAN_W  = 24;
  localparam int unsigned VEC_W  = 48;
  localparam int unsigned COMP_W = 16;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned IDX_W  = 3;
  // screen offset magnitude and signed width (Q.16)
  localparam int unsigned OFSQ_W = 38;
  localparam int unsigned OFS_W  = 39;

  typedef enum logic [IDX_W-1:0] {
    CFG_FORWARD = 3'd0,
    CFG_RIGHT   = 3'd1,
    CFG_UP      = 3'd2,
    CFG_TAN_X   = 3'd3,
    CFG_TAN_Y   = 3'd4,
    CFG_WIDTH   = 3'd5,
    CFG_HEIGHT  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
    logic                     zero_length;
  } ray_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] sx;
    logic signed [OFS_W-1:0] sy;
  } ofs_t;

endpackage

// File: src/pinhole_ray_direction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_ray_direction_unit
// Pinhole camera primary ray directions, one pixel per clock while busy is low.
// ----------------------------------------------------------------------------
// A pixel beat is taken on every clock where start is high and busy is low;
// busy stays low in normal use, so one pixel may be issued every cycle. Each
// pixel gives one result beat, flagged by result_valid_o for a single cycle,
// in issue order. The pipeline holds the bit-per-stage dividers (38 stages
// for the screen offset, FRAC_BITS + 1 for the final normalise) and the
// 32-stage square root. The receiver cannot stall the result, so it must
// take every beat. Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write it only while nothing is in flight, as
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_unit #(
  parameter int unsigned MAX_SIDE  = 4096,
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  prd_pkg::pixel_t           pixel_i,
  output logic                      result_valid_o,
  output prd_pkg::ray_t             result_o,
  input  logic                      cfg_we_i,
  input  logic [prd_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [prd_pkg::CFG_W-1:0] cfg_wdata_i
);
  import prd_pkg::*;

  // configuration registers
  logic [VEC_W-1:0]  fwd_q, rgt_q, up_q;
  logic [TAN_W-1:0]  tan_x_q, tan_y_q;
  logic [SIDE_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q    <= '0;
      rgt_q    <= '0;
      up_q     <= '0;
      tan_x_q  <= TAN_W'(65536);
      tan_y_q  <= TAN_W'(65536);
      width_q  <= SIDE_W'(1);
      height_q <= SIDE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FORWARD: fwd_q    <= cfg_wdata_i[VEC_W-1:0];
        CFG_RIGHT:   rgt_q    <= cfg_wdata_i[VEC_W-1:0];
        CFG_UP:      up_q     <= cfg_wdata_i[VEC_W-1:0];
        CFG_TAN_X:   tan_x_q  <= cfg_wdata_i[TAN_W-1:0];
        CFG_TAN_Y:   tan_y_q  <= cfg_wdata_i[TAN_W-1:0];
        CFG_WIDTH:   width_q  <= cfg_wdata_i[SIDE_W-1:0];
        CFG_HEIGHT:  height_q <= cfg_wdata_i[SIDE_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  logic take;
  assign take = start & ~busy;

  // front: pixel to signed screen offsets
  logic fr_vld;
  ofs_t fr_ofs;

  prd_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk_i, .rst_ni,
    .valid_i(take), .pix_i(pixel_i),
    .tan_x_i(tan_x_q), .tan_y_i(tan_y_q),
    .width_i(width_q), .height_i(height_q),
    .valid_o(fr_vld), .ofs_o(fr_ofs)
  );

  // two-beat queue between front and back
  ofs_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop = (cnt_q != 2'd0); // back half never stalls

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (fr_vld) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(fr_vld) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_vld) q_mem[wr_ptr_q] <= fr_ofs;
  end

  // queue full holds off new pixels
  assign busy = (cnt_q == 2'd2);

  // back: direction, normalise, saturate
  prd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(pop), .ofs_i(q_mem[rd_ptr_q]),
    .fwd_i(fwd_q), .rgt_i(rgt_q), .up_i(up_q),
    .valid_o(result_valid_o), .ray_o(result_o)
  );

endmodule

// File: src/prd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prd_div #(
  parameter int unsigned NW = 39,
  parameter int unsigned DW = 14,
  parameter int unsigned QB = 38,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [QB-1:0] quot_o,
  output logic [PW-1:0] pay_o
);

  logic          vld_q [QB];
  logic [DW-1:0] rem_q [QB];
  logic [QB-1:0] lq_q  [QB];
  logic [DW-1:0] dvs_q [QB];
  logic [PW-1:0] pay_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic          v_s;
    logic [DW-1:0] rem_s;
    logic [DW-1:0] dvs_s;
    logic [QB-1:0] lq_s;
    logic [PW-1:0] pay_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (s == 0) begin : g_first
      assign v_s   = valid_i;
      assign rem_s = DW'(dividend_i[NW-1:QB]);
      assign lq_s  = dividend_i[QB-1:0];
      assign dvs_s = divisor_i;
      assign pay_s = pay_i;
    end else begin : g_next
      assign v_s   = vld_q[s-1];
      assign rem_s = rem_q[s-1];
      assign lq_s  = lq_q[s-1];
      assign dvs_s = dvs_q[s-1];
      assign pay_s = pay_q[s-1];
    end

    assign trial = {rem_s, lq_s[QB-1]};
    assign diff  = trial - {1'b0, dvs_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (trial >= {1'b0, dvs_s}) begin
        rem_q[s] <= diff[DW-1:0];
        lq_q[s]  <= {lq_s[QB-2:0], 1'b1};
      end else begin
        rem_q[s] <= trial[DW-1:0];
        lq_q[s]  <= {lq_s[QB-2:0], 1'b0};
      end
      dvs_q[s] <= dvs_s;
      pay_q[s] <= pay_s;
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quot_o  = lq_q[QB-1];
  assign pay_o   = pay_q[QB-1];

endmodule

// File: src/prd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_isqrt
// Pipelined integer square root of a 64-bit word, one root bit per stage.
// ----------------------------------------------------------------------------
module prd_isqrt #(
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [63:0]   rad_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [31:0]   root_o,
  output logic [PW-1:0] pay_o
);

  localparam int unsigned NS = 32;

  logic          vld_q  [NS];
  logic [33:0]   rem_q  [NS];
  logic [31:0]   root_q [NS];
  logic [63:0]   rad_q  [NS];
  logic [PW-1:0] pay_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_s;
    logic [33:0]   rem_s;
    logic [31:0]   root_s;
    logic [63:0]   rad_s;
    logic [PW-1:0] pay_s;
    logic [35:0]   cur;
    logic [35:0]   trial;

    if (s == 0) begin : g_first
      assign v_s    = valid_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign rad_s  = rad_i;
      assign pay_s  = pay_i;
    end else begin : g_next
      assign v_s    = vld_q[s-1];
      assign rem_s  = rem_q[s-1];
      assign root_s = root_q[s-1];
      assign rad_s  = rad_q[s-1];
      assign pay_s  = pay_q[s-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_s, rad_s[63:62]};
    assign trial = {2'b00, root_s, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cur >= trial) begin
        rem_q[s]  <= 34'(cur - trial);
        root_q[s] <= {root_s[30:0], 1'b1};
      end else begin
        rem_q[s]  <= cur[33:0];
        root_q[s] <= {root_s[30:0], 1'b0};
      end
      rad_q[s] <= {rad_s[61:0], 2'b00};
      pay_q[s] <= pay_s;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign pay_o   = pay_q[NS-1];

endmodule

// File: src/prd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_front
// Pixel to screen offsets: centre offset, tangent scale, rounded divide.
// ----------------------------------------------------------------------------
module prd_front #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  prd_pkg::pixel_t            pix_i,
  input  logic [prd_pkg::TAN_W-1:0]  tan_x_i,
  input  logic [prd_pkg::TAN_W-1:0]  tan_y_i,
  input  logic [prd_pkg::SIDE_W-1:0] width_i,
  input  logic [prd_pkg::SIDE_W-1:0] height_i,
  output logic                       valid_o,
  output prd_pkg::ofs_t              ofs_o
);
  import prd_pkg::*;

  localparam int unsigned SIDE_MAXV = (1 << SIDE_W) - 1;
  localparam int unsigned SIDE_CAP  = (MAX_SIDE > SIDE_MAXV) ? SIDE_MAXV : MAX_SIDE;
  localparam int unsigned NUM_W     = SIDE_W + 2;
  localparam int unsigned MAG_W     = SIDE_W;
  localparam int unsigned PROD_W    = MAG_W + TAN_W;
  localparam int unsigned DVD_W     = OFS_W;
  localparam int unsigned DVS_W     = SIDE_W + 1;

  logic [SIDE_W-1:0] w_side;
  logic [SIDE_W-1:0] h_side;

  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    if (s == '0) begin
      r = SIDE_W'(1);
    end else if (32'(s) > SIDE_CAP) begin
      r = SIDE_W'(SIDE_CAP);
    end else begin
      r = s;
    end
    return r;
  endfunction

  assign w_side = side_of(width_i);
  assign h_side = side_of(height_i);

  // centre offsets
  logic signed [NUM_W-1:0] num_x;
  logic signed [NUM_W-1:0] num_y;
  logic [NUM_W-1:0]        abs_x;
  logic [NUM_W-1:0]        abs_y;

  assign num_x = signed'(NUM_W'({pix_i.pixel_x, 1'b1}) - NUM_W'(w_side));
  assign num_y = signed'(NUM_W'(h_side) - NUM_W'({pix_i.pixel_y, 1'b1}));
  assign abs_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
  assign abs_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);

  logic             s0_vld_q;
  logic [MAG_W-1:0] s0_mx_q, s0_my_q;
  logic             s0_nx_q, s0_ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_mx_q <= abs_x[MAG_W-1:0];
    s0_my_q <= abs_y[MAG_W-1:0];
    s0_nx_q <= num_x[NUM_W-1];
    s0_ny_q <= num_y[NUM_W-1];
  end

  // tangent scale, dividend 2*mag*tan + side for round half away
  logic              s1_vld_q;
  logic [DVD_W-1:0]  s1_dx_q, s1_dy_q;
  logic [DVS_W-1:0]  s1_wx_q, s1_wy_q;
  logic              s1_nx_q, s1_ny_q;
  logic [PROD_W-1:0] prod_x, prod_y;

  assign prod_x = PROD_W'(s0_mx_q) * PROD_W'(tan_x_i);
  assign prod_y = PROD_W'(s0_my_q) * PROD_W'(tan_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q <= DVD_W'({prod_x, 1'b0}) + DVD_W'(w_side);
    s1_dy_q <= DVD_W'({prod_y, 1'b0}) + DVD_W'(h_side);
    s1_wx_q <= {w_side, 1'b0};
    s1_wy_q <= {h_side, 1'b0};
    s1_nx_q <= s0_nx_q;
    s1_ny_q <= s0_ny_q;
  end

  logic              dx_vld, dy_vld;
  logic [OFSQ_W-1:0] qx, qy;
  logic              nx, ny;

  prd_div #(.NW(DVD_W), .DW(DVS_W), .QB(OFSQ_W), .PW(1)) u_div_x (
    .clk_i, .rst_ni,
    .valid_i(s1_vld_q), .dividend_i(s1_dx_q), .divisor_i(s1_wx_q), .pay_i(s1_nx_q),
    .valid_o(dx_vld), .quot_o(qx), .pay_o(nx)
  );

  prd_div #(.NW(DVD_W), .DW(DVS_W), .QB(OFSQ_W), .PW(1)) u_div_y (
    .clk_i, .rst_ni,
    .valid_i(s1_vld_q), .dividend_i(s1_dy_q), .divisor_i(s1_wy_q), .pay_i(s1_ny_q),
    .valid_o(dy_vld), .quot_o(qy), .pay_o(ny)
  );

  logic vld_q;
  ofs_t ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dx_vld & dy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_q.sx <= nx ? -signed'(OFS_W'(qx)) : signed'(OFS_W'(qx));
    ofs_q.sy <= ny ? -signed'(OFS_W'(qy)) : signed'(OFS_W'(qy));
  end

  assign valid_o = vld_q;
  assign ofs_o   = ofs_q;

endmodule

// File: src/prd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_back
// Direction sum, block normalisation, square root and per-axis divide.
// ----------------------------------------------------------------------------
module prd_back #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  prd_pkg::ofs_t             ofs_i,
  input  logic [prd_pkg::VEC_W-1:0] fwd_i,
  input  logic [prd_pkg::VEC_W-1:0] rgt_i,
  input  logic [prd_pkg::VEC_W-1:0] up_i,
  output logic                      valid_o,
  output prd_pkg::ray_t             ray_o
);
  import prd_pkg::*;

  localparam int unsigned PRD_W = OFS_W + COMP_W;
  localparam int unsigned D_W   = 57;
  localparam int unsigned POS_W = 6;
  localparam int unsigned N_W   = 31;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned NUM_W = N_W + QW + 1;
  localparam int unsigned DEN_W = 33;
  localparam int unsigned PAY_W = 3 * N_W + 4;

  // products
  logic                    b1_vld_q;
  logic signed [PRD_W-1:0] b1_pr_q [3];
  logic signed [PRD_W-1:0] b1_pu_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
    end else begin
      b1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      b1_pr_q[k] <= PRD_W'(ofs_i.sx) * PRD_W'(signed'(rgt_i[COMP_W*k +: COMP_W]));
      b1_pu_q[k] <= PRD_W'(ofs_i.sy) * PRD_W'(signed'(up_i[COMP_W*k +: COMP_W]));
    end
  end

  // sum and magnitude
  logic             b2_vld_q;
  logic [D_W-1:0]   b2_mag_q [3];
  logic [2:0]       b2_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_vld_q <= 1'b0;
    end else begin
      b2_vld_q <= b1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [D_W-1:0] d;
      d = (D_W'(signed'(fwd_i[COMP_W*k +: COMP_W])) <<< 16)
        + D_W'(b1_pr_q[k]) + D_W'(b1_pu_q[k]);
      b2_neg_q[k] <= d[D_W-1];
      b2_mag_q[k] <= d[D_W-1] ? D_W'(-d) : D_W'(d);
    end
  end

  // largest magnitude
  logic           b3_vld_q;
  logic [D_W-1:0] b3_mag_q [3];
  logic [D_W-1:0] b3_max_q;
  logic [2:0]     b3_neg_q;
  logic [D_W-1:0] max01;

  assign max01 = (b2_mag_q[0] > b2_mag_q[1]) ? b2_mag_q[0] : b2_mag_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b3_vld_q <= 1'b0;
    end else begin
      b3_vld_q <= b2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b3_mag_q <= b2_mag_q;
    b3_neg_q <= b2_neg_q;
    b3_max_q <= (max01 > b2_mag_q[2]) ? max01 : b2_mag_q[2];
  end

  // leading one of the largest
  logic             b4_vld_q;
  logic [D_W-1:0]   b4_mag_q [3];
  logic [POS_W-1:0] b4_pos_q;
  logic             b4_zero_q;
  logic [2:0]       b4_neg_q;
  logic [POS_W-1:0] lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < D_W; i++) begin
      if (b3_max_q[i]) lead = POS_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b4_vld_q <= 1'b0;
    end else begin
      b4_vld_q <= b3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b4_mag_q  <= b3_mag_q;
    b4_neg_q  <= b3_neg_q;
    b4_pos_q  <= lead;
    b4_zero_q <= (b3_max_q == '0);
  end

  // common shift, largest lands in [2^30, 2^31)
  logic           b5_vld_q;
  logic [N_W-1:0] b5_n_q [3];
  logic           b5_zero_q;
  logic [2:0]     b5_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b5_vld_q <= 1'b0;
    end else begin
      b5_vld_q <= b4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (b4_pos_q >= POS_W'(N_W - 1)) begin
        b5_n_q[k] <= N_W'(b4_mag_q[k] >> (b4_pos_q - POS_W'(N_W - 1)));
      end else begin
        b5_n_q[k] <= N_W'(b4_mag_q[k] << (POS_W'(N_W - 1) - b4_pos_q));
      end
    end
    b5_zero_q <= b4_zero_q;
    b5_neg_q  <= b4_neg_q;
  end

  // squares
  logic           b6_vld_q;
  logic [61:0]    b6_sq_q [3];
  logic [N_W-1:0] b6_n_q  [3];
  logic           b6_zero_q;
  logic [2:0]     b6_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b6_vld_q <= 1'b0;
    end else begin
      b6_vld_q <= b5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      b6_sq_q[k] <= 62'(b5_n_q[k]) * 62'(b5_n_q[k]);
    end
    b6_n_q    <= b5_n_q;
    b6_zero_q <= b5_zero_q;
    b6_neg_q  <= b5_neg_q;
  end

  // sum of squares
  logic             b7_vld_q;
  logic [63:0]      b7_sum_q;
  logic [PAY_W-1:0] b7_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b7_vld_q <= 1'b0;
    end else begin
      b7_vld_q <= b6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b7_sum_q <= 64'(b6_sq_q[0]) + 64'(b6_sq_q[1]) + 64'(b6_sq_q[2]);
    b7_pay_q <= {b6_n_q[0], b6_n_q[1], b6_n_q[2], b6_neg_q, b6_zero_q};
  end

  logic             sq_vld;
  logic [31:0]      root;
  logic [PAY_W-1:0] sq_pay;

  prd_isqrt #(.PW(PAY_W)) u_isqrt (
    .clk_i, .rst_ni,
    .valid_i(b7_vld_q), .rad_i(b7_sum_q), .pay_i(b7_pay_q),
    .valid_o(sq_vld), .root_o(root), .pay_o(sq_pay)
  );

  // dividends for round half up of mag*2^F/m
  logic             b8_vld_q;
  logic [NUM_W-1:0] b8_num_q [3];
  logic [DEN_W-1:0] b8_den_q;
  logic [2:0]       b8_neg_q;
  logic             b8_zero_q;
  logic [N_W-1:0]   sq_n [3];

  assign sq_n[0] = sq_pay[PAY_W-1 -: N_W];
  assign sq_n[1] = sq_pay[PAY_W-1-N_W -: N_W];
  assign sq_n[2] = sq_pay[PAY_W-1-2*N_W -: N_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b8_vld_q <= 1'b0;
    end else begin
      b8_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      b8_num_q[k] <= NUM_W'({sq_n[k], QW'(0)}) + NUM_W'(root);
    end
    b8_den_q  <= {root, 1'b0};
    b8_neg_q  <= sq_pay[3:1];
    b8_zero_q <= sq_pay[0];
  end

  logic          dv_vld [3];
  logic [QW-1:0] dv_q   [3];
  logic [1:0]    dv_pay [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    prd_div #(.NW(NUM_W), .DW(DEN_W), .QB(QW), .PW(2)) u_div (
      .clk_i, .rst_ni,
      .valid_i(b8_vld_q), .dividend_i(b8_num_q[k]), .divisor_i(b8_den_q),
      .pay_i({b8_neg_q[k], b8_zero_q}),
      .valid_o(dv_vld[k]), .quot_o(dv_q[k]), .pay_o(dv_pay[k])
    );
  end

  // saturate to Q1.15
  function automatic logic [COMP_W-1:0] sat(input logic [QW-1:0] q, input logic neg,
                                           input logic zero);
    logic [63:0]       qe;
    logic [COMP_W-1:0] r;
    qe = 64'(q);
    if (zero) begin
      r = '0;
    end else if (neg) begin
      r = (qe > 64'd32768) ? 16'h8000 : 16'(~qe[15:0] + 16'd1);
    end else begin
      r = (qe > 64'd32767) ? 16'h7fff : qe[15:0];
    end
    return r;
  endfunction

  logic vld_q;
  ray_t ray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dv_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q.dir_x       <= signed'(sat(dv_q[0], dv_pay[0][1], dv_pay[0][0]));
    ray_q.dir_y       <= signed'(sat(dv_q[1], dv_pay[1][1], dv_pay[1][0]));
    ray_q.dir_z       <= signed'(sat(dv_q[2], dv_pay[2][1], dv_pay[2][0]));
    ray_q.zero_length <= dv_pay[0][0];
  end

  assign valid_o = vld_q;
  assign ray_o   = ray_q;

endmodule

// File: src/prd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_checker
// Port-level checks of the pinhole ray direction unit.
// ----------------------------------------------------------------------------
module prd_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  prd_pkg::pixel_t           pixel_i,
  input  logic                      result_valid_o,
  input  prd_pkg::ray_t             result_o,
  input  logic                      cfg_we_i,
  input  logic [prd_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [prd_pkg::CFG_W-1:0] cfg_wdata_i
);

  // queue drains each cycle, so no beat is ever refused
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // flagged zero length carries a zero vector
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.zero_length |->
      result_o.dir_x == 16'sd0 && result_o.dir_y == 16'sd0 && result_o.dir_z == 16'sd0)
    else $error("zero length beat with nonzero direction");

  // a normalised direction is never all zero
  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.zero_length |->
      result_o.dir_x != 16'sd0 || result_o.dir_y != 16'sd0 || result_o.dir_z != 16'sd0)
    else $error("normalised direction collapsed to zero");

  // no result straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !result_valid_o)
    else $error("result beat right after reset");

endmodule

bind pinhole_ray_direction_unit prd_checker u_prd_checker (.*);
